[hdl/ngh_pkg.sv]
// Shared constants and helpers for the noise gate with hold smoothing.
`default_nettype none
package ngh_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned HOLD_WIDTH_DEF   = 20;

  localparam int unsigned GAIN_WIDTH    = 16;
  localparam int unsigned CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ATTACK    = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RELEASE   = 2'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HOLD      = 2'd3;

  localparam logic [GAIN_WIDTH-1:0] GAIN_FULL = 16'hFFFF;
  localparam logic [GAIN_WIDTH:0]   ONE_Q16   = 17'h10000;

  function automatic int unsigned max2(int unsigned a, int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

[hdl/noise_gate_hold_smoothing.sv]
// Top level: noise gate with hold counter and attack/release gain smoothing.
`default_nettype none
// Noise gate. Each input word is one signed sample; each gives exactly one output word
// holding the gated sample and the updated Q0.16 gain. The gate opens (target gain
// full scale) when the saturated magnitude reaches the threshold, else the target is
// zero. A falling or steady target first runs the hold counter up past hold_samples,
// then smooths with attack_coeff; a rising target smooths with release_coeff and
// clears the counter. One multiplier is shared by every product: c*g, (1-c)*target
// and sample*gain each take one pass through it. A smoothed word goes through the gate
// decision, the c*g and (1-c)*target passes and the gain update before the sample*gain
// pass; while the hold counter runs, the decision goes straight to sample*gain. The
// input is stalled until the result is loaded into the output register, and a new word
// is taken in the cycle after that load, even if that result is still waiting. A
// still-full, stalled output register holds the result back and so stalls the input.
// Configuration writes are taken at any time but are meant for idle periods only.
module noise_gate_hold_smoothing #(
  parameter int unsigned SampleWidth = ngh_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned HoldWidth   = ngh_pkg::HOLD_WIDTH_DEF,
  localparam int unsigned CfgWidth   =
    ngh_pkg::max2(ngh_pkg::max2(SampleWidth - 1, ngh_pkg::GAIN_WIDTH), HoldWidth)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input word
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [SampleWidth-1:0]       sample_in_i,
  // output word
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [SampleWidth-1:0]            sample_out_o,
  output logic [ngh_pkg::GAIN_WIDTH-1:0]           gain_now_o,
  // config writes
  input  wire logic                                cfg_we_i,
  input  wire logic [ngh_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  wire logic [CfgWidth-1:0]                 cfg_data_i
);
  import ngh_pkg::*;

  // multiplier operand widths: A takes the sample or a 17-bit unsigned coefficient
  localparam int unsigned MulAW = max2(SampleWidth, GAIN_WIDTH + 2);
  localparam int unsigned MulBW = GAIN_WIDTH + 1;
  localparam int unsigned MulPW = MulAW + MulBW;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // wait for a sample
  localparam logic [2:0] S_DEC  = 3'd1;  // gate decision, issue c*g or step the hold counter
  localparam logic [2:0] S_M1   = 3'd2;  // latch c*g, issue (1-c)*target
  localparam logic [2:0] S_M2   = 3'd3;  // sum and update gain
  localparam logic [2:0] S_M3   = 3'd4;  // issue sample*gain
  localparam logic [2:0] S_M4   = 3'd5;  // load output register

  logic [2:0] state_q, state_d;

  // configuration
  logic [SampleWidth-2:0] threshold_q;
  logic [GAIN_WIDTH-1:0]  attack_q;
  logic [GAIN_WIDTH-1:0]  release_q;
  logic [HoldWidth-1:0]   hold_samples_q;

  // kept state
  logic [GAIN_WIDTH-1:0]  gain_q, gain_d;
  logic [HoldWidth:0]     hold_cnt_q, hold_cnt_d;

  // per-word working registers
  logic signed [SampleWidth-1:0] sample_q;
  logic [GAIN_WIDTH-1:0]  coef_q, coef_d;
  logic                   open_q, open_d;
  logic [31:0]            acc_q;

  // output register
  logic                          out_valid_q;
  logic signed [SampleWidth-1:0] sample_out_q;
  logic [GAIN_WIDTH-1:0]         gain_out_q;

  // multiplier hookup
  logic                    mul_en;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  // saturated magnitude
  logic [SampleWidth-1:0] neg;
  logic [SampleWidth-2:0] mag;
  logic                   open_now;
  logic                   tgt_le;
  logic [31:0]            sum;
  logic                   out_load;
  logic [GAIN_WIDTH:0]    one_minus_c;

  always_comb begin
    neg = -sample_q;
    if (!sample_q[SampleWidth-1]) begin
      mag = sample_q[SampleWidth-2:0];
    end else if (neg[SampleWidth-1]) begin
      mag = '1;  // most negative code saturates
    end else begin
      mag = neg[SampleWidth-2:0];
    end
    open_now = !(mag < threshold_q);
    // closed target is zero, never above the gain; open is only "not above" at full scale
    tgt_le   = !open_now || (gain_q == GAIN_FULL);
  end

  assign one_minus_c = ONE_Q16 - {1'b0, coef_q};
  assign sum         = acc_q + mul_p[31:0];
  assign out_load    = (state_q == S_M4) && (!out_valid_q || !out_stall_i);

  // sequencer and datapath control
  always_comb begin
    state_d    = state_q;
    gain_d     = gain_q;
    hold_cnt_d = hold_cnt_q;
    coef_d     = coef_q;
    open_d     = open_q;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        open_d = open_now;
        if (tgt_le && (hold_cnt_q <= {1'b0, hold_samples_q})) begin
          hold_cnt_d = hold_cnt_q + 1'b1;
          state_d    = S_M3;
        end else begin
          if (tgt_le) begin
            coef_d = attack_q;
          end else begin
            coef_d     = release_q;
            hold_cnt_d = '0;
          end
          mul_en  = 1'b1;
          mul_a   = MulAW'(coef_d);
          mul_b   = MulBW'(gain_q);
          state_d = S_M1;
        end
      end
      S_M1: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(one_minus_c);
        mul_b   = open_q ? MulBW'(GAIN_FULL) : '0;
        state_d = S_M2;
      end
      S_M2: begin
        gain_d  = sum[31:16];
        state_d = S_M3;
      end
      S_M3: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(sample_q);
        mul_b   = MulBW'(gain_q);
        state_d = S_M4;
      end
      S_M4: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  ngh_mul #(
    .AW(MulAW),
    .BW(MulBW)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      threshold_q    <= '0;
      attack_q       <= '0;
      release_q      <= '0;
      hold_samples_q <= '0;
      gain_q         <= '0;
      hold_cnt_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      gain_q     <= gain_d;
      hold_cnt_q <= hold_cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: threshold_q    <= cfg_data_i[SampleWidth-2:0];
          CFG_ATTACK:    attack_q       <= cfg_data_i[GAIN_WIDTH-1:0];
          CFG_RELEASE:   release_q      <= cfg_data_i[GAIN_WIDTH-1:0];
          CFG_HOLD:      hold_samples_q <= cfg_data_i[HoldWidth-1:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      sample_q <= sample_in_i;
    end
    coef_q <= coef_d;
    open_q <= open_d;
    if (state_q == S_M1) begin
      acc_q <= mul_p[31:0];
    end
    if (out_load) begin
      // arithmetic shift: floor of sample*gain/65536
      sample_out_q <= mul_p[GAIN_WIDTH +: SampleWidth];
      gain_out_q   <= gain_q;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign gain_now_o   = gain_out_q;

`ifndef SYNTHESIS
  // counter stops at hold_samples+1, so the top bit only ever appears alone
  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_cnt_q[HoldWidth] |-> (hold_cnt_q[HoldWidth-1:0] == '0))
    else $error("hold counter beyond its range");

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DEC))
    else $error("accepted word did not start the gate decision");

  a_gain_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_M2) |=> $stable(gain_q))
    else $error("gain changed outside the update step");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_M4))
    else $error("output word appeared without a finished item");
`endif

endmodule
`default_nettype wire

[hdl/ngh_mul.sv]
// Shared signed multiplier with a registered product.
`default_nettype none
module ngh_mul #(
  parameter int unsigned AW = 18,
  parameter int unsigned BW = 17
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [AW-1:0]    a_i,
  input  wire logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0]      p_o
);

  logic signed [AW+BW-1:0] p_q;

  // product holds while disabled so a stalled result stays put
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire
